FILE: rtl/core/tce_pkg.sv
package tce_pkg;

	localparam int RAW_W = 12;
	localparam int DIM_W = 10;
	localparam int SPAN_W = 12;
	localparam int PAIR_W = 13;
	localparam int DIFF_W = 14;
	localparam int SUM_W = 14;
	localparam int DIV_N = 29;
	localparam int DIV_D_W = 11;
	localparam int SLOPE_W = DIV_N + 1;
	localparam int PROD_W = SLOPE_W + SPAN_W;
	localparam int FRAC_HALF = 15;
	localparam int ROUND_SHIFT = 17;
	localparam int RECIP_SHIFT = 20;
	localparam int FIFO_DEPTH = 2;
	localparam int INSET_DIVIDER_DEF = 8;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_SCREEN_WIDTH = 4'h0;
	localparam logic [APB_AW-1:0] REG_SCREEN_HEIGHT = 4'h4;
	localparam logic [APB_AW-1:0] REG_MIN_SPAN = 4'h8;

	localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST = 10'd240;
	localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 10'd320;
	localparam logic [RAW_W-1:0] MIN_SPAN_RST = 12'd200;

	typedef struct packed {
		logic [3:0][RAW_W-1:0] px;
		logic [3:0][RAW_W-1:0] py;
		logic [DIM_W-1:0] scr_w;
		logic [DIM_W-1:0] scr_h;
		logic [RAW_W-1:0] min_span;
	} set_t;

	typedef struct packed {
		logic start;
		logic neg;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic signed [SLOPE_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: rtl/core/touch_corner_extrapolator.sv
// Four-point touch calibration: corner extrapolator.
// Input stream (s_t*): one averaged raw point per item, four per run; point i
// sits on the right inset column when bit1 of i is set, bottom row when bit0 is.
// Output stream (m_t*): four corner items per run in order top-left,
// bottom-left, top-right, bottom-right; m_tlast marks the fourth, m_tuser
// carries the span sanity flag.
// APB port: screen_width at 0x0, screen_height at 0x4, min_span at 0x8; the
// values in force when the fourth point is taken apply to that run.
// Points are taken one per cycle unless the queue is full. A complete run
// enters a two-set queue, so the next run can be loaded while the current one
// is worked on. The back end runs four slope divisions on one shared divider,
// each with 29 shift steps; corners then leave one per cycle while the
// receiver is ready. A zero inset span skips its division.
// Reset clears the point count, the queue and the output; registers return to
// 240, 320 and 200. A stalled receiver holds the current corner; the back end
// waits, and the input stalls only once the queue is full.
module touch_corner_extrapolator #(
	parameter int INSET_DIVIDER = tce_pkg::INSET_DIVIDER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [23:0] s_tdata,    // raw_x[11:0], raw_y[23:12]
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata,   // corner_index[1:0], corner_x[13:2], corner_y[25:14], zero
	output logic m_tuser,          // spans_ok
	output logic m_tlast,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tce_pkg::APB_AW-1:0] paddr,
	input logic [tce_pkg::APB_DW-1:0] pwdata,
	output logic [tce_pkg::APB_DW-1:0] prdata,
	output logic pready
);

	localparam int RAW_W = tce_pkg::RAW_W;
	localparam int DIM_W = tce_pkg::DIM_W;

	logic [DIM_W-1:0] scr_w_q, scr_h_q;
	logic [RAW_W-1:0] min_span_q;
	logic cfg_wr;
	logic push, full, pop, not_empty;
	tce_pkg::set_t push_set, pop_set;
	tce_pkg::div_req_t div_req;
	tce_pkg::div_rsp_t div_rsp;
	logic [1:0] corner_index;
	logic [RAW_W-1:0] corner_x, corner_y;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= tce_pkg::SCREEN_WIDTH_RST;
			scr_h_q <= tce_pkg::SCREEN_HEIGHT_RST;
			min_span_q <= tce_pkg::MIN_SPAN_RST;
		end else if (cfg_wr) begin
			case (paddr)
				tce_pkg::REG_SCREEN_WIDTH: scr_w_q <= pwdata[DIM_W-1:0];
				tce_pkg::REG_SCREEN_HEIGHT: scr_h_q <= pwdata[DIM_W-1:0];
				tce_pkg::REG_MIN_SPAN: min_span_q <= pwdata[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			tce_pkg::REG_SCREEN_WIDTH: prdata = {{(tce_pkg::APB_DW-DIM_W){1'b0}}, scr_w_q};
			tce_pkg::REG_SCREEN_HEIGHT: prdata = {{(tce_pkg::APB_DW-DIM_W){1'b0}}, scr_h_q};
			tce_pkg::REG_MIN_SPAN: prdata = {{(tce_pkg::APB_DW-RAW_W){1'b0}}, min_span_q};
			default: prdata = '0;
		endcase
	end

	tce_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.raw_x(s_tdata[RAW_W-1:0]),
		.raw_y(s_tdata[2*RAW_W-1:RAW_W]),
		.scr_w(scr_w_q),
		.scr_h(scr_h_q),
		.min_span(min_span_q),
		.full(full),
		.push(push),
		.push_set(push_set)
	);

	tce_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_set(push_set),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.pop_set(pop_set)
	);

	tce_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	tce_back #(
		.INSET_DIVIDER(INSET_DIVIDER)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.set_valid(not_empty),
		.set_in(pop_set),
		.set_pop(pop),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.corner_index(corner_index),
		.corner_x(corner_x),
		.corner_y(corner_y),
		.spans_ok(m_tuser),
		.last_corner(m_tlast)
	);

	assign m_tdata = {6'b0, corner_y, corner_x, corner_index};

endmodule

FILE: rtl/core/tce_front.sv
module tce_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [tce_pkg::RAW_W-1:0] raw_x,
	input logic [tce_pkg::RAW_W-1:0] raw_y,
	input logic [tce_pkg::DIM_W-1:0] scr_w,
	input logic [tce_pkg::DIM_W-1:0] scr_h,
	input logic [tce_pkg::RAW_W-1:0] min_span,
	input logic full,
	output logic push,
	output tce_pkg::set_t push_set
);

	logic [1:0] count_q;
	logic [2:0][tce_pkg::RAW_W-1:0] px_q;
	logic [2:0][tce_pkg::RAW_W-1:0] py_q;
	logic accept;
	logic fourth;

	assign fourth = (count_q == 2'd3);
	assign in_ready = !fourth || !full;
	assign accept = in_valid && in_ready;
	assign push = accept && fourth;

	always_comb begin
		push_set.px = {raw_x, px_q[2], px_q[1], px_q[0]};
		push_set.py = {raw_y, py_q[2], py_q[1], py_q[0]};
		push_set.scr_w = scr_w;
		push_set.scr_h = scr_h;
		push_set.min_span = min_span;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (accept) begin
			count_q <= count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !fourth) begin
			px_q[count_q] <= raw_x;
			py_q[count_q] <= raw_y;
		end
	end

endmodule

FILE: rtl/core/tce_fifo.sv
module tce_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tce_pkg::set_t push_set,
	output logic full,
	input logic pop,
	output logic not_empty,
	output tce_pkg::set_t pop_set
);

	localparam int DEPTH = tce_pkg::FIFO_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	tce_pkg::set_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign pop_set = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_set;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("set pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("set popped from empty queue");

endmodule

FILE: rtl/core/tce_div.sv
module tce_div (
	input logic clk,
	input logic arst_n,
	input tce_pkg::div_req_t req,
	output tce_pkg::div_rsp_t rsp
);

	localparam int N = tce_pkg::DIV_N;
	localparam int DW = tce_pkg::DIV_D_W;
	localparam int CNT_W = $clog2(N);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N - 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N-1:0] n_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic neg_q;
	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic ge;

	assign rem_sh = {rem_q, n_q[N-1]};
	assign ge = (rem_sh >= {1'b0, d_q});
	assign rem_sub = rem_sh - {1'b0, d_q};

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		rsp.quot = neg_q ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.dividend;
			d_q <= req.divisor;
			neg_q <= req.neg;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[N-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (!busy_q && !done_q))
		else $error("divider started while busy");

endmodule

FILE: rtl/core/tce_back.sv
module tce_back #(
	parameter int INSET_DIVIDER = tce_pkg::INSET_DIVIDER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic set_valid,
	input tce_pkg::set_t set_in,
	output logic set_pop,
	output tce_pkg::div_req_t div_req,
	input tce_pkg::div_rsp_t div_rsp,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] corner_index,
	output logic [tce_pkg::RAW_W-1:0] corner_x,
	output logic [tce_pkg::RAW_W-1:0] corner_y,
	output logic spans_ok,
	output logic last_corner
);

	localparam int RAW_W = tce_pkg::RAW_W;
	localparam int DIM_W = tce_pkg::DIM_W;
	localparam int SPAN_W = tce_pkg::SPAN_W;
	localparam int PAIR_W = tce_pkg::PAIR_W;
	localparam int DIFF_W = tce_pkg::DIFF_W;
	localparam int SUM_W = tce_pkg::SUM_W;
	localparam int SLOPE_W = tce_pkg::SLOPE_W;
	localparam int PROD_W = tce_pkg::PROD_W;
	localparam int RS = tce_pkg::RECIP_SHIFT;
	localparam int RECIP = ((1 << RS) + INSET_DIVIDER - 1) / INSET_DIVIDER;
	localparam int RECIP_W = RS + 1;
	localparam int MUL_W = DIM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam int TOP_W = PROD_W - SUM_W - tce_pkg::FRAC_HALF;
	localparam logic signed [PROD_W-1:0] HALF_ROUND = PROD_W'(1) <<< (tce_pkg::ROUND_SHIFT - 1);
	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_LOAD = 8'b0000_0010,
		ST_PREP = 8'b0000_0100,
		ST_DIV = 8'b0000_1000,
		ST_MUL = 8'b0001_0000,
		ST_CORN = 8'b0010_0000,
		ST_SPREAD = 8'b0100_0000,
		ST_EMIT = 8'b1000_0000
	} state_t;

	function automatic logic [DIM_W-1:0] inset(input logic [DIM_W-1:0] d);
		logic [MUL_W-1:0] p;
		p = {{RECIP_W{1'b0}}, d} * {{DIM_W{1'b0}}, RECIP_C};
		return p[RS +: DIM_W];
	endfunction

	function automatic logic [SPAN_W-1:0] inner_span(input logic [DIM_W-1:0] d);
		return {2'b00, d} - SPAN_W'(1) - {1'b0, inset(d), 1'b0};
	endfunction

	function automatic logic [RAW_W-1:0] spread(input logic [3:0][RAW_W-1:0] v);
		logic [RAW_W-1:0] lo01, hi01, lo23, hi23, lo, hi;
		lo01 = (v[0] < v[1]) ? v[0] : v[1];
		hi01 = (v[0] < v[1]) ? v[1] : v[0];
		lo23 = (v[2] < v[3]) ? v[2] : v[3];
		hi23 = (v[2] < v[3]) ? v[3] : v[2];
		lo = (lo01 < lo23) ? lo01 : lo23;
		hi = (hi01 > hi23) ? hi01 : hi23;
		return hi - lo;
	endfunction

	state_t state_q;
	tce_pkg::set_t set_q;
	logic signed [SPAN_W-1:0] span_x_q, span_y_q, wm1_q, hm1_q;
	logic axis_q, sel_q, mul_ph_q;
	logic signed [SLOPE_W-1:0] slope_a_q, slope_b_q;
	logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
	logic [SUM_W-1:0] sum_q;
	logic [1:0] ci_q, eidx_q;
	logic [3:0][RAW_W-1:0] cx_q, cy_q;
	logic ok_q;
	logic out_valid_q, out_ok_q, out_last_q;
	logic [1:0] out_idx_q;
	logic [RAW_W-1:0] out_x_q, out_y_q;

	logic [3:0][RAW_W-1:0] s;
	logic [PAIR_W-1:0] p_hi, p_lo;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] diff_abs;
	logic signed [SPAN_W-1:0] span;
	logic [SPAN_W-1:0] span_abs;
	logic span_zero;
	logic signed [PROD_W-1:0] v2, t2, term_a, term_b;
	logic [RAW_W-1:0] corner_val;
	logic emit_go;

	assign s = axis_q ? set_q.py : set_q.px;

	always_comb begin
		if (sel_q) begin
			p_hi = {1'b0, s[1]} + {1'b0, s[3]};
			p_lo = {1'b0, s[0]} + {1'b0, s[2]};
			span = span_y_q;
		end else begin
			p_hi = {1'b0, s[2]} + {1'b0, s[3]};
			p_lo = {1'b0, s[0]} + {1'b0, s[1]};
			span = span_x_q;
		end
		diff = $signed({1'b0, p_hi}) - $signed({1'b0, p_lo});
		diff_abs = diff[DIFF_W-1] ? -diff : diff;
		span_abs = span[SPAN_W-1] ? -span : span;
		span_zero = (span == '0);
	end

	always_comb begin
		div_req.start = (state_q == ST_PREP) && !span_zero;
		div_req.neg = diff[DIFF_W-1] ^ span[SPAN_W-1];
		div_req.dividend = {diff_abs[DIFF_W-2:0], {(tce_pkg::DIV_N - DIFF_W + 1){1'b0}}};
		div_req.divisor = {span_abs[tce_pkg::DIV_D_W-2:0], 1'b0};
	end

	always_comb begin
		term_a = ci_q[1] ? prod_a_q : -prod_a_q;
		term_b = ci_q[0] ? prod_b_q : -prod_b_q;
		v2 = $signed({{TOP_W{1'b0}}, sum_q, {tce_pkg::FRAC_HALF{1'b0}}}) + term_a + term_b;
		t2 = v2 + HALF_ROUND;
		if (v2[PROD_W-1]) begin
			corner_val = '0;
		end else if (|t2[PROD_W-1:tce_pkg::ROUND_SHIFT+RAW_W]) begin
			corner_val = RAW_MAX;
		end else begin
			corner_val = t2[tce_pkg::ROUND_SHIFT +: RAW_W];
		end
	end

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign set_pop = (state_q == ST_IDLE) && set_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= 1'b0;
			sel_q <= 1'b0;
			mul_ph_q <= 1'b0;
			ci_q <= 2'd0;
			eidx_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (set_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					axis_q <= 1'b0;
					sel_q <= 1'b0;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (!span_zero) begin
						state_q <= ST_DIV;
					end else if (!sel_q) begin
						sel_q <= 1'b1;
					end else begin
						mul_ph_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (!sel_q) begin
							sel_q <= 1'b1;
							state_q <= ST_PREP;
						end else begin
							mul_ph_q <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					mul_ph_q <= 1'b1;
					if (mul_ph_q) begin
						ci_q <= 2'd0;
						state_q <= ST_CORN;
					end
				end
				ST_CORN: begin
					ci_q <= ci_q + 2'd1;
					if (ci_q == 2'd3) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
							sel_q <= 1'b0;
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_SPREAD;
						end
					end
				end
				ST_SPREAD: begin
					eidx_q <= 2'd0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						eidx_q <= eidx_q + 2'd1;
						if (eidx_q == 2'd3) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (set_pop) begin
			set_q <= set_in;
		end
		if (state_q == ST_LOAD) begin
			span_x_q <= $signed(inner_span(set_q.scr_w));
			span_y_q <= $signed(inner_span(set_q.scr_h));
			wm1_q <= $signed({2'b00, set_q.scr_w} - SPAN_W'(1));
			hm1_q <= $signed({2'b00, set_q.scr_h} - SPAN_W'(1));
		end
		if (state_q == ST_PREP && span_zero) begin
			if (sel_q) begin
				slope_b_q <= '0;
			end else begin
				slope_a_q <= '0;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (sel_q) begin
				slope_b_q <= div_rsp.quot;
			end else begin
				slope_a_q <= div_rsp.quot;
			end
		end
		if (state_q == ST_MUL) begin
			if (mul_ph_q) begin
				prod_b_q <= slope_b_q * hm1_q;
			end else begin
				prod_a_q <= slope_a_q * wm1_q;
				sum_q <= {2'b00, s[0]} + {2'b00, s[1]} + {2'b00, s[2]} + {2'b00, s[3]};
			end
		end
		if (state_q == ST_CORN) begin
			if (axis_q) begin
				cy_q[ci_q] <= corner_val;
			end else begin
				cx_q[ci_q] <= corner_val;
			end
		end
		if (state_q == ST_SPREAD) begin
			ok_q <= (spread(cx_q) >= set_q.min_span) && (spread(cy_q) >= set_q.min_span);
		end
		if (emit_go) begin
			out_idx_q <= eidx_q;
			out_x_q <= cx_q[eidx_q];
			out_y_q <= cy_q[eidx_q];
			out_ok_q <= ok_q;
			out_last_q <= (eidx_q == 2'd3);
		end
	end

	assign out_valid = out_valid_q;
	assign corner_index = out_idx_q;
	assign corner_x = out_x_q;
	assign corner_y = out_y_q;
	assign spans_ok = out_ok_q;
	assign last_corner = out_last_q;

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
		else $error("waiting on divider that is not running");

	a_last_on_corner3: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_idx_q == 2'd3)))
		else $error("last flag not on fourth corner");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && eidx_q == 2'd3) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after fourth corner");

endmodule
